>>> sv/vector_stroke_text_generator_defines.svh
// ----------------------------------------------------------------------------
// Stroke text generator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_STROKE_TEXT_GENERATOR_DEFINES_SVH
`define VECTOR_STROKE_TEXT_GENERATOR_DEFINES_SVH

// same-cycle implication
`define VSTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/vstg_pkg.sv
// ----------------------------------------------------------------------------
// Stroke text generator package
// Glyph and segment tables, offset selector codes, fraction helpers.
// ----------------------------------------------------------------------------
package vstg_pkg;

  localparam int NUM_GLYPHS = 20;
  localparam int NUM_SEGS   = 70;

  typedef logic [4:0]  gid_t;    // glyph number
  typedef logic [3:0]  fsel_t;   // offset selector
  typedef logic [6:0]  saddr_t;  // segment table address
  typedef logic [2:0]  scnt_t;   // segment count / index within glyph
  typedef logic [10:0] dim_t;    // glyph height or width
  typedef logic [1:0]  cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_GLYPH_HEIGHT = 2'd0;
  localparam cfg_idx_t REG_GLYPH_WIDTH  = 2'd1;
  localparam cfg_idx_t REG_LETTER_GAP   = 2'd2;

  // offset selectors, applied to width (x) or height (y)
  localparam fsel_t F_ZERO   = 4'd0;
  localparam fsel_t F_FULL   = 4'd1;
  localparam fsel_t F_HALF   = 4'd2;
  localparam fsel_t F_THIRD  = 4'd3;
  localparam fsel_t F_QUART  = 4'd4;
  localparam fsel_t F_3QUART = 4'd5;
  localparam fsel_t F_FIFTH  = 4'd6;
  localparam fsel_t F_2THIRD = 4'd7;
  localparam fsel_t F_SIXTH  = 4'd8;

  typedef struct packed {
    fsel_t x0;
    fsel_t y0;
    fsel_t x1;
    fsel_t y1;
  } seg_def_t;

  typedef struct packed {
    dim_t half;
    dim_t third;
    dim_t quart;
    dim_t tquart;
    dim_t fifth;
    dim_t tthird;
    dim_t sixth;
  } frac_t;

  typedef struct packed {
    logic hit;
    gid_t gid;
  } glyph_hit_t;

  // one nibble per selector: x0 y0 x1 y1
  localparam logic [15:0] SEG_ROM [NUM_SEGS] = '{
    16'h0001, 16'h0120, 16'h2011, 16'h1110,                      // m
    16'h0111, 16'h0010, 16'h2021,                                // i
    16'h0010, 16'h1012, 16'h1202, 16'h0201, 16'h0111,            // s
    16'h0010, 16'h0001,                                          // l
    16'h0010, 16'h0001, 16'h0212, 16'h0111,                      // e
    16'h0010, 16'h0001, 16'h0111,                                // c
    16'h0010, 16'h0001, 16'h0111, 16'h1011,                      // o
    16'h0021, 16'h2110, 16'h4252,                                // a
    16'h0001, 16'h0110, 16'h1011,                                // n
    16'h0010, 16'h6061, 16'h0111, 16'h1011,                      // d
    16'h0001, 16'h0111, 16'h1112, 16'h0212,                      // p
    16'h0001, 16'h0111, 16'h1112, 16'h0212, 16'h0210,            // r
    16'h0010, 16'h0001, 16'h0111, 16'h1013, 16'h1323,            // g
    16'h2001, 16'h2011,                                          // v
    16'h2027, 16'h2701, 16'h2711,                                // y
    16'h0100, 16'h0010, 16'h1011,                                // u
    16'h0701, 16'h0111, 16'h1112, 16'h1222, 16'h2223, 16'h2820,  // ?
    16'h2000, 16'h0001, 16'h0121,                                // [
    16'h2010, 16'h1011, 16'h1121,                                // ]
    16'h0011                                                     // /
  };

  localparam saddr_t GLYPH_FIRST [NUM_GLYPHS] = '{
    7'd0,  7'd4,  7'd7,  7'd12, 7'd14, 7'd18, 7'd21, 7'd25, 7'd28, 7'd31,
    7'd35, 7'd39, 7'd44, 7'd49, 7'd51, 7'd54, 7'd57, 7'd63, 7'd66, 7'd69
  };

  localparam scnt_t GLYPH_COUNT [NUM_GLYPHS] = '{
    3'd4, 3'd3, 3'd5, 3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4,
    3'd4, 3'd5, 3'd5, 3'd2, 3'd3, 3'd3, 3'd6, 3'd3, 3'd3, 3'd1
  };

  // case-folds and maps a character onto its glyph number
  function automatic glyph_hit_t glyph_find(logic [7:0] ch);
    logic [7:0] lc;
    glyph_hit_t r;
    lc = ch;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      lc = ch + 8'h20;
    end
    r.hit = 1'b1;
    r.gid = 5'd0;
    unique case (lc)
      8'h6d: r.gid = 5'd0;   // m
      8'h69: r.gid = 5'd1;   // i
      8'h73: r.gid = 5'd2;   // s
      8'h6c: r.gid = 5'd3;   // l
      8'h65: r.gid = 5'd4;   // e
      8'h63: r.gid = 5'd5;   // c
      8'h6f: r.gid = 5'd6;   // o
      8'h61: r.gid = 5'd7;   // a
      8'h6e: r.gid = 5'd8;   // n
      8'h64: r.gid = 5'd9;   // d
      8'h70: r.gid = 5'd10;  // p
      8'h72: r.gid = 5'd11;  // r
      8'h67: r.gid = 5'd12;  // g
      8'h76: r.gid = 5'd13;  // v
      8'h79: r.gid = 5'd14;  // y
      8'h75: r.gid = 5'd15;  // u
      8'h3f: r.gid = 5'd16;  // ?
      8'h5b: r.gid = 5'd17;  // [
      8'h5d: r.gid = 5'd18;  // ]
      8'h2f: r.gid = 5'd19;  // /
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // truncating fractions via reciprocal multiply; exact for all 11-bit inputs
  function automatic frac_t frac_calc(dim_t v);
    logic [23:0] p3;
    logic [23:0] p23;
    logic [23:0] p5;
    logic [12:0] v3;
    frac_t f;
    p3  = 24'(v) * 24'd2731;
    p23 = 24'({v, 1'b0}) * 24'd2731;
    p5  = 24'(v) * 24'd1639;
    v3  = 13'(v) + 13'({v, 1'b0});
    f.half   = {1'b0, v[10:1]};
    f.third  = p3[23:13];
    f.quart  = {2'b00, v[10:2]};
    f.tquart = v3[12:2];
    f.fifth  = p5[23:13];
    f.tthird = p23[23:13];
    f.sixth  = {1'b0, p3[23:14]};
    return f;
  endfunction

  function automatic dim_t frac_pick(frac_t f, dim_t full, fsel_t sel);
    dim_t r;
    unique case (sel)
      F_FULL:   r = full;
      F_HALF:   r = f.half;
      F_THIRD:  r = f.third;
      F_QUART:  r = f.quart;
      F_3QUART: r = f.tquart;
      F_FIFTH:  r = f.fifth;
      F_2THIRD: r = f.tthird;
      F_SIXTH:  r = f.sixth;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/vector_stroke_text_generator.sv
// ----------------------------------------------------------------------------
// Vector stroke text generator
// Turns characters into line segments of a small stroke font.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake         Payload
// in_      input      in_valid/stall    char_code, word_start, start_x, start_y
// out_     output     out_valid/stall   seg_x0, seg_y0, seg_x1, seg_y1, last
// cfg_     input      cfg_we            cfg_index, cfg_wdata
//
// A character request passes the front end combinationally and is queued; the
// back end then walks its glyph of one to six segments, one segment per cycle
// while out_stall is low, so the character rate depends on the segment count.
// The first segment is offered after it passes the queue and the output register.
// Characters with no strokes do not reach the queue. Reset is synchronous;
// it clears the pen, the queue and the output stage and restores the
// register defaults.
// out_stall holds the output register and, through the queue, fills up to
// in_stall.
// ----------------------------------------------------------------------------
`include "vector_stroke_text_generator_defines.svh"

module vector_stroke_text_generator import vstg_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int Q_DEPTH    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_word_start,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_seg_x0,
  output logic signed [15:0] out_seg_y0,
  output logic signed [15:0] out_seg_x1,
  output logic signed [15:0] out_seg_y1,
  output logic               out_last_segment
);

  localparam int JOB_W = 2 * COORD_BITS + $bits(gid_t);

  dim_t       glyph_height_r, glyph_width_r;
  logic [7:0] letter_gap_r;

  logic                  q_push, q_full, q_pop, q_valid;
  logic [COORD_BITS-1:0] push_pen_x, push_pen_y;
  gid_t                  push_gid;
  logic [JOB_W-1:0]      head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_height_r <= 11'd32;
      glyph_width_r  <= 11'd24;
      letter_gap_r   <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata;
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata;
        REG_LETTER_GAP:   letter_gap_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  vstg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_code  (in_char_code),
    .in_word_start (in_word_start),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .glyph_width   (glyph_width_r),
    .letter_gap    (letter_gap_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_pen_x       (push_pen_x),
    .q_pen_y       (push_pen_y),
    .q_gid         (push_gid)
  );

  vstg_fifo #(.WIDTH(JOB_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({push_pen_x, push_pen_y, push_gid}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head)
  );

  vstg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .glyph_height     (glyph_height_r),
    .glyph_width      (glyph_width_r),
    .job_valid        (q_valid),
    .job_pen_x        (head[JOB_W-1 -: COORD_BITS]),
    .job_pen_y        (head[$bits(gid_t) +: COORD_BITS]),
    .job_gid          (head[$bits(gid_t)-1:0]),
    .job_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment)
  );

  `VSTG_ASSERT_NOW(a_no_overflow, q_push, !q_full, "queue push while full")
  `VSTG_ASSERT_NEXT(a_pop_is_last, q_pop, out_valid && out_last_segment, "pop before last")
  `VSTG_ASSERT_NEXT(a_queue_drains, q_valid && !out_valid, out_valid, "queued glyph not started")

endmodule

>>> sv/vstg_front.sv
// ----------------------------------------------------------------------------
// Stroke text generator front end
// Takes character requests, keeps the pen, queues drawable glyphs.
// ----------------------------------------------------------------------------
module vstg_front import vstg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_code,
  input  logic                  in_word_start,
  input  logic signed [15:0]    in_start_x,
  input  logic signed [15:0]    in_start_y,
  input  dim_t                  glyph_width,
  input  logic [7:0]            letter_gap,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [COORD_BITS-1:0] q_pen_x,
  output logic [COORD_BITS-1:0] q_pen_y,
  output gid_t                  q_gid
);

  localparam int EXT_W = (COORD_BITS > 16) ? COORD_BITS : 16;

  logic [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic signed [EXT_W-1:0] sx_ext, sy_ext;
  logic [11:0] advance;
  logic accept;
  glyph_hit_t look;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign sx_ext = EXT_W'(in_start_x);
  assign sy_ext = EXT_W'(in_start_y);
  assign look   = glyph_find(in_char_code);
  assign advance = 12'(glyph_width) + 12'(letter_gap);

  always_comb begin
    q_pen_x = in_word_start ? sx_ext[COORD_BITS-1:0] : pen_x_r;
    q_pen_y = in_word_start ? sy_ext[COORD_BITS-1:0] : pen_y_r;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      // pen moves on even for characters with no strokes
      pen_x_nxt = q_pen_x + COORD_BITS'(advance);
      pen_y_nxt = q_pen_y;
    end
  end

  assign q_push = accept && look.hit;
  assign q_gid  = look.gid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

>>> sv/vstg_fifo.sv
// ----------------------------------------------------------------------------
// Stroke text generator job queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module vstg_fifo #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/vstg_back.sv
// ----------------------------------------------------------------------------
// Stroke text generator back end
// Walks a queued glyph's segments, one endpoint pair per cycle while not stalled.
// ----------------------------------------------------------------------------
module vstg_back import vstg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dim_t                  glyph_height,
  input  dim_t                  glyph_width,
  input  logic                  job_valid,
  input  logic [COORD_BITS-1:0] job_pen_x,
  input  logic [COORD_BITS-1:0] job_pen_y,
  input  gid_t                  job_gid,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_seg_x0,
  output logic signed [15:0]    out_seg_y0,
  output logic signed [15:0]    out_seg_x1,
  output logic signed [15:0]    out_seg_y1,
  output logic                  out_last_segment
);

  localparam int EXT_W = (COORD_BITS > 16) ? COORD_BITS : 16;

  frac_t hfrac_r, wfrac_r;
  scnt_t seg_k_r;
  logic  out_valid_r;
  logic [15:0] x0_r, y0_r, x1_r, y1_r;
  logic  last_r;

  saddr_t   saddr;
  seg_def_t seg;
  logic     last, go;
  logic [COORD_BITS-1:0] x0_c, y0_c, x1_c, y1_c;

  function automatic logic [15:0] to_out(logic [COORD_BITS-1:0] c);
    logic [EXT_W-1:0] e;
    e = EXT_W'(c);
    return e[15:0];
  endfunction

  // fractions only follow a config write; user must write while idle, unenforced
  always_ff @(posedge clk) begin
    hfrac_r <= frac_calc(glyph_height);
    wfrac_r <= frac_calc(glyph_width);
  end

  assign saddr = GLYPH_FIRST[job_gid] + saddr_t'(seg_k_r);
  assign seg   = seg_def_t'(SEG_ROM[saddr]);
  assign last  = (seg_k_r == GLYPH_COUNT[job_gid] - 3'd1);
  assign go    = job_valid && (!out_valid_r || !out_stall);
  assign job_pop = go && last;

  assign x0_c = job_pen_x + COORD_BITS'(frac_pick(wfrac_r, glyph_width, seg.x0));
  assign y0_c = job_pen_y - COORD_BITS'(frac_pick(hfrac_r, glyph_height, seg.y0));
  assign x1_c = job_pen_x + COORD_BITS'(frac_pick(wfrac_r, glyph_width, seg.x1));
  assign y1_c = job_pen_y - COORD_BITS'(frac_pick(hfrac_r, glyph_height, seg.y1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seg_k_r     <= '0;
    end else begin
      if (go) begin
        out_valid_r <= 1'b1;
        seg_k_r     <= last ? '0 : seg_k_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x0_r   <= to_out(x0_c);
      y0_r   <= to_out(y0_c);
      x1_r   <= to_out(x1_c);
      y1_r   <= to_out(y1_c);
      last_r <= last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seg_x0       = x0_r;
  assign out_seg_y0       = y0_r;
  assign out_seg_x1       = x1_r;
  assign out_seg_y1       = y1_r;
  assign out_last_segment = last_r;

endmodule

>>> dv/vstg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke text generator checker
// Follows register writes and accepted character requests, builds the
// expected segment stream from its own glyph tables and compares each
// accepted segment against the oldest one still owed.
// ----------------------------------------------------------------------------
module vstg_checker import vstg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [10:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_word_start,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_seg_x0,
  input  logic signed [15:0] out_seg_y0,
  input  logic signed [15:0] out_seg_x1,
  input  logic signed [15:0] out_seg_y1,
  input  logic               out_last_segment,
  output int                 errors,
  output int                 outstanding
);

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic        last;
  } segment_t;

  // up to six selector words, first stroke in the top 16 bits
  typedef struct {
    int          count;
    logic [95:0] codes;
  } strokes_t;

  segment_t    segment_q[$];
  dim_t        height;
  dim_t        width;
  logic [7:0]  gap;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  int          fail_cnt;

  function automatic logic [15:0] scaled(dim_t v, fsel_t sel);
    int u;
    int r;
    u = v;
    case (sel)
      F_FULL:   r = u;
      F_HALF:   r = u / 2;
      F_THIRD:  r = u / 3;
      F_QUART:  r = u / 4;
      F_3QUART: r = (3 * u) / 4;
      F_FIFTH:  r = u / 5;
      F_2THIRD: r = (2 * u) / 3;
      F_SIXTH:  r = u / 6;
      default:  r = 0;
    endcase
    return 16'(r);
  endfunction

  function automatic strokes_t glyph_strokes(logic [7:0] lc);
    strokes_t g;
    g.count = 0;
    g.codes = '0;
    case (lc)
      "m": begin g.count = 4; g.codes = {64'h0001_0120_2011_1110, 32'h0}; end
      "i": begin g.count = 3; g.codes = {48'h0111_0010_2021, 48'h0}; end
      "s": begin g.count = 5; g.codes = {80'h0010_1012_1202_0201_0111, 16'h0}; end
      "l": begin g.count = 2; g.codes = {32'h0010_0001, 64'h0}; end
      "e": begin g.count = 4; g.codes = {64'h0010_0001_0212_0111, 32'h0}; end
      "c": begin g.count = 3; g.codes = {48'h0010_0001_0111, 48'h0}; end
      "o": begin g.count = 4; g.codes = {64'h0010_0001_0111_1011, 32'h0}; end
      "a": begin g.count = 3; g.codes = {48'h0021_2110_4252, 48'h0}; end
      "n": begin g.count = 3; g.codes = {48'h0001_0110_1011, 48'h0}; end
      "d": begin g.count = 4; g.codes = {64'h0010_6061_0111_1011, 32'h0}; end
      "p": begin g.count = 4; g.codes = {64'h0001_0111_1112_0212, 32'h0}; end
      "r": begin g.count = 5; g.codes = {80'h0001_0111_1112_0212_0210, 16'h0}; end
      "g": begin g.count = 5; g.codes = {80'h0010_0001_0111_1013_1323, 16'h0}; end
      "v": begin g.count = 2; g.codes = {32'h2001_2011, 64'h0}; end
      "y": begin g.count = 3; g.codes = {48'h2027_2701_2711, 48'h0}; end
      "u": begin g.count = 3; g.codes = {48'h0100_0010_1011, 48'h0}; end
      "?": begin g.count = 6; g.codes = 96'h0701_0111_1112_1222_2223_2820; end
      "[": begin g.count = 3; g.codes = {48'h2000_0001_0121, 48'h0}; end
      "]": begin g.count = 3; g.codes = {48'h2010_1011_1121, 48'h0}; end
      "/": begin g.count = 1; g.codes = {16'h0011, 80'h0}; end
      default: g.count = 0;
    endcase
    return g;
  endfunction

  task automatic draw_char(logic [7:0] ch, logic ws, logic [15:0] sx, logic [15:0] sy);
    logic [7:0] lc;
    strokes_t   g;
    seg_def_t   sd;
    segment_t   s;
    if (ws) begin
      pen_x = sx;
      pen_y = sy;
    end
    lc = ch;
    if (ch >= "A" && ch <= "Z") begin
      lc = ch + 8'h20;
    end
    g = glyph_strokes(lc);
    for (int k = 0; k < g.count; k++) begin
      sd     = g.codes[95 - 16 * k -: 16];
      s.x0   = pen_x + scaled(width, sd.x0);
      s.y0   = pen_y - scaled(height, sd.y0);
      s.x1   = pen_x + scaled(width, sd.x1);
      s.y1   = pen_y - scaled(height, sd.y1);
      s.last = (k == g.count - 1);
      segment_q.push_back(s);
    end
    // pen moves on even for characters with no strokes
    pen_x = pen_x + 16'(width) + 16'(gap);
  endtask

  task automatic flag(string what, segment_t want, segment_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected x0=%0d y0=%0d x1=%0d y1=%0d last=%0b",
               $signed(want.x0), $signed(want.y0), $signed(want.x1), $signed(want.y1),
               want.last);
      $display("  actual   x0=%0d y0=%0d x1=%0d y1=%0d last=%0b",
               $signed(got.x0), $signed(got.y0), $signed(got.x1), $signed(got.y1),
               got.last);
    end
  endtask

  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (!rst_n) begin
      height   = 11'd32;
      width    = 11'd24;
      gap      = 8'd10;
      pen_x    = '0;
      pen_y    = '0;
      fail_cnt = 0;
      segment_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_seg_x0, out_seg_y0, out_seg_x1, out_seg_y1, out_last_segment};
        if (segment_q.size() == 0) begin
          flag("segment with none outstanding", '0, got);
        end else begin
          want = segment_q.pop_front();
          if (got.x0 !== want.x0 || got.y0 !== want.y0 || got.x1 !== want.x1 ||
              got.y1 !== want.y1 || got.last !== want.last) begin
            flag("segment mismatch", want, got);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GLYPH_HEIGHT: height = cfg_wdata;
          REG_GLYPH_WIDTH:  width  = cfg_wdata;
          REG_LETTER_GAP:   gap    = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        draw_char(in_char_code, in_word_start, in_start_x, in_start_y);
      end
    end
    errors      <= fail_cnt;
    outstanding <= segment_q.size();
  end

endmodule

>>> dv/tb_vector_stroke_text_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke text generator testbench
// Sends a directed set of characters at reset settings, then random text
// under several register settings; random gaps and output stalls skip phase 3.
// ----------------------------------------------------------------------------
module tb_vector_stroke_text_generator;
  import vstg_pkg::*;

  localparam int       LIMIT    = 400000;
  localparam int       TAIL     = 10;
  localparam int       IDLE_PCT = 27;
  localparam int       PHASES   = 6;
  localparam int       PER_PHASE = 41;
  localparam cfg_idx_t REG_SPARE = 2'd3;  // no register behind this index

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = REG_GLYPH_HEIGHT;
  logic [10:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code = '0;
  logic               in_word_start = 1'b0;
  logic signed [15:0] in_start_x = '0;
  logic signed [15:0] in_start_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_seg_x0;
  logic signed [15:0] out_seg_y0;
  logic signed [15:0] out_seg_x1;
  logic signed [15:0] out_seg_y1;
  logic               out_last_segment;
  int                 errors;
  int                 outstanding;
  int                 cycles = 0;
  logic               calm = 1'b0;
  string              glyph_set = "misleconadprgvyu?[]/";
  string              directed_text = "mISlEcoAndpRgvYu?[]/";

  vector_stroke_text_generator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_word_start    (in_word_start),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment)
  );

  vstg_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_word_start    (in_word_start),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_seg_x0       (out_seg_x0),
    .out_seg_y0       (out_seg_y0),
    .out_seg_x1       (out_seg_x1),
    .out_seg_y1       (out_seg_y1),
    .out_last_segment (out_last_segment),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_char(logic [7:0] ch, logic ws, logic [15:0] sx, logic [15:0] sy);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= ch;
    in_word_start <= ws;
    in_start_x    <= sx;
    in_start_y    <= sy;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic [7:0] ch;
    if ($urandom_range(99) < 70) begin
      ch = glyph_set[$urandom_range(glyph_set.len() - 1)];
      if (ch >= "a" && ch <= "z" && $urandom_range(1)) begin
        ch = ch - 8'h20;
      end
    end else begin
      ch = 8'($urandom_range(255));
    end
    send_char(ch, $urandom_range(99) < 20, 16'($urandom), 16'($urandom));
  endtask

  // registers may only change once the pipe is empty, including strokeless requests
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic program_regs(logic [10:0] h, logic [10:0] w, logic [10:0] g);
    write_reg(REG_GLYPH_HEIGHT, h);
    write_reg(REG_GLYPH_WIDTH, w);
    write_reg(REG_LETTER_GAP, g);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every glyph, mixed case, pen wrapping past both limits
    for (int i = 0; i < directed_text.len(); i++) begin
      send_char(directed_text[i], i == 0, 16'sd32700, -16'sd32763);
    end
    send_char(8'h00, 1'b1, 16'sh8000, 16'sd32767);
    send_char(8'hff, 1'b0, '0, '0);
    send_char("Z", 1'b0, '0, '0);
    send_char("{", 1'b0, '0, '0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_regs(11'h7ff, 11'h7ff, 11'h7ff);
        1: program_regs(11'h000, 11'h000, 11'h000);
        2: begin
          write_reg(REG_SPARE, 11'($urandom));
          program_regs(11'($urandom), 11'($urandom), 11'($urandom));
        end
        default: program_regs(11'($urandom_range(200)), 11'($urandom_range(200)),
                              11'($urandom));
      endcase
      calm <= (phase == 3);
      for (int n = 0; n < PER_PHASE; n++) begin
        send_random();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> vector_stroke_text_generator.f
+incdir+sv
sv/vstg_pkg.sv
sv/vstg_front.sv
sv/vstg_fifo.sv
sv/vstg_back.sv
sv/vector_stroke_text_generator.sv
dv/vstg_checker.sv
dv/tb_vector_stroke_text_generator.sv
